[src/sse_pkg.sv]
// Shared types and fixed field widths for the sorted set engine.
package sse_pkg;

    localparam int KEY_BITS      = 32;
    localparam int REQ_BITS      = 3;
    localparam int IN_USER_BITS  = 4;
    localparam int STATUS_BITS   = 2;
    localparam int COUNT_BITS    = 5;
    localparam int OUT_DATA_BITS = 40;

    typedef enum logic [REQ_BITS-1:0] {
        REQ_INSERT = 3'd0,
        REQ_REMOVE = 3'd1,
        REQ_EXISTS = 3'd2,
        REQ_MIN    = 3'd3,
        REQ_MAX    = 3'd4,
        REQ_PRED   = 3'd5,
        REQ_SUCC   = 3'd6,
        REQ_CLEAR  = 3'd7
    } req_t;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_OK     = 2'd0,
        ST_ABSENT = 2'd1,
        ST_DUP    = 2'd2,
        ST_FULL   = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SRCH,
        S_CMP,
        S_PROBE,
        S_FRD,
        S_FDAT,
        S_UP,
        S_DN,
        S_PUT,
        S_DONE
    } state_t;

endpackage

[src/sorted_set_engine_top.sv]
// A search request runs a binary search over the held keys and then probes entry lo;
// pred/succ then fetch the value. Min/max fetch the end entry; clear goes straight to done.
// Insert moves keys up one per step and then places the key; remove, and a take on
// min/max/pred/succ, move keys down one per step. The store's single write port sets this.
// One request is in flight at a time; the next is taken once the last reaches the output reg.
// Reset (aresetn low, synchronous): empty set, idle sequencer, no result; store not cleared.
module sorted_set_engine_top #(
    parameter int CAPACITY  = 16,
    parameter int KEY_WIDTH = 32
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [sse_pkg::KEY_BITS-1:0]       s_tdata,   // key[31:0]
    input  logic [sse_pkg::IN_USER_BITS-1:0]   s_tuser,   // req_type[2:0], take[3]
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [sse_pkg::OUT_DATA_BITS-1:0]  m_tdata    // status[1:0], value[33:2],
                                                          // count[38:34], zero[39]
);

    import sse_pkg::*;

    // Keys are masked to KEY_WIDTH but never wider than the key field.
    localparam int KW = (KEY_WIDTH < KEY_BITS) ? KEY_WIDTH : KEY_BITS;
    localparam int AW = $clog2(CAPACITY);
    localparam int FW = $clog2(CAPACITY + 1);
    localparam logic [FW-1:0] FILL_MAX = FW'(CAPACITY);
    localparam logic [FW-1:0] ONE      = FW'(1);
    localparam logic [FW-1:0] TWO      = FW'(2);

    // Sequencer and working registers
    state_t          state_reg, state_next;
    req_t            op_reg, op_next;
    logic            take_reg, take_next;
    logic [KW-1:0]   key_reg, key_next;
    logic [FW-1:0]   lo_reg, lo_next;
    logic [FW-1:0]   hi_reg, hi_next;
    logic [FW-1:0]   mid_reg, mid_next;
    logic [FW-1:0]   cur_reg, cur_next;
    logic [FW-1:0]   fill_reg, fill_next;
    status_t         status_reg, status_next;
    logic [KW-1:0]   value_reg, value_next;

    // Output register
    logic                    m_valid_reg, m_valid_next;
    status_t                 m_status_reg, m_status_next;
    logic [KEY_BITS-1:0]     m_value_reg, m_value_next;
    logic [COUNT_BITS-1:0]   m_count_reg, m_count_next;

    // Store port
    logic            mem_we;
    logic [AW-1:0]   mem_waddr;
    logic [KW-1:0]   mem_wdata;
    logic [FW-1:0]   rd_idx;
    logic [KW-1:0]   rd_data;

    // Input beat decode
    logic            in_accept;
    req_t            in_op;
    logic            in_take;
    logic [KW-1:0]   in_key;
    logic            in_search;

    // Shared compare/step terms
    logic [FW-1:0]   mid_w;
    logic            lo_lt_hi;
    logic            hit;
    logic            full;
    logic [FW-1:0]   succ_idx;
    logic [FW-1:0]   lo_inc;
    logic [FW-1:0]   cur_inc;
    logic [FW-1:0]   cur_dec;
    logic            dn_more;
    logic            out_free;

    logic [KW+KEY_BITS-1:0]   value_ext;
    logic [FW+COUNT_BITS-1:0] fill_ext;

    assign s_tready  = (state_reg == S_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign in_op     = req_t'(s_tuser[REQ_BITS-1:0]);
    assign in_take   = s_tuser[REQ_BITS];
    assign in_key    = s_tdata[KW-1:0];
    assign in_search = in_op inside {REQ_INSERT, REQ_REMOVE, REQ_EXISTS, REQ_PRED, REQ_SUCC};

    // Binary search keeps [lo, hi); the probe of entry lo follows once the range closes.
    assign mid_w    = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign lo_lt_hi = (lo_reg < hi_reg);
    assign hit      = (lo_reg < fill_reg) && (rd_data == key_reg);
    assign full     = (fill_reg == FILL_MAX);
    assign succ_idx = lo_reg + {{(FW-1){1'b0}}, hit};
    assign lo_inc   = lo_reg + ONE;
    assign cur_inc  = cur_reg + ONE;
    assign cur_dec  = cur_reg - ONE;
    assign dn_more  = ({1'b0, cur_reg} + {1'b0, TWO}) < {1'b0, fill_reg};
    assign out_free = !m_valid_reg || m_tready;

    assign value_ext = {{KEY_BITS{1'b0}}, value_reg};
    assign fill_ext  = {{COUNT_BITS{1'b0}}, fill_reg};

    sse_mem #(
        .DEPTH (CAPACITY),
        .WIDTH (KW)
    ) u_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (rd_idx[AW-1:0]),
        .rdata (rd_data)
    );

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (in_accept) begin
                    if (in_search) begin
                        state_next = S_SRCH;
                    end else if (in_op == REQ_CLEAR || fill_reg == '0) begin
                        state_next = S_DONE;
                    end else begin
                        state_next = S_FRD;
                    end
                end
            end
            S_SRCH:  state_next = lo_lt_hi ? S_CMP : S_PROBE;
            S_CMP:   state_next = S_SRCH;
            S_PROBE: begin
                case (op_reg)
                    REQ_INSERT: begin
                        if (hit || full) begin
                            state_next = S_DONE;
                        end else begin
                            state_next = (fill_reg == lo_reg) ? S_PUT : S_UP;
                        end
                    end
                    REQ_REMOVE: state_next = (hit && lo_inc < fill_reg) ? S_DN : S_DONE;
                    REQ_PRED:   state_next = (lo_reg != '0) ? S_FRD : S_DONE;
                    REQ_SUCC:   state_next = (succ_idx < fill_reg) ? S_FRD : S_DONE;
                    default:    state_next = S_DONE;
                endcase
            end
            S_FRD:   state_next = S_FDAT;
            S_FDAT:  state_next = (take_reg && cur_inc < fill_reg) ? S_DN : S_DONE;
            S_UP:    state_next = (cur_dec == lo_reg) ? S_PUT : S_UP;
            S_DN:    state_next = dn_more ? S_DN : S_DONE;
            S_PUT:   state_next = S_DONE;
            S_DONE:  state_next = out_free ? S_IDLE : S_DONE;
            default: state_next = S_IDLE;
        endcase
    end

    // Datapath, store port and output register loads
    always_comb begin
        op_next       = op_reg;
        take_next     = take_reg;
        key_next      = key_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        mid_next      = mid_reg;
        cur_next      = cur_reg;
        fill_next     = fill_reg;
        status_next   = status_reg;
        value_next    = value_reg;
        m_valid_next  = m_valid_reg;
        m_status_next = m_status_reg;
        m_value_next  = m_value_reg;
        m_count_next  = m_count_reg;
        mem_we        = 1'b0;
        mem_waddr     = cur_reg[AW-1:0];
        mem_wdata     = rd_data;
        rd_idx        = cur_reg;

        // Drop the beat once taken
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (in_accept) begin
                    op_next     = in_op;
                    take_next   = in_take;
                    key_next    = in_key;
                    lo_next     = '0;
                    hi_next     = fill_reg;
                    status_next = ST_OK;
                    value_next  = '0;
                    cur_next    = (in_op == REQ_MAX) ? (fill_reg - ONE) : '0;
                    if (in_op == REQ_CLEAR) begin
                        fill_next = '0;
                    end else if (!in_search && fill_reg == '0) begin
                        status_next = ST_ABSENT;
                    end
                end
            end
            S_SRCH: begin
                rd_idx   = lo_lt_hi ? mid_w : lo_reg;
                mid_next = mid_w;
            end
            S_CMP: begin
                if (rd_data < key_reg) begin
                    lo_next = mid_reg + ONE;
                end else begin
                    hi_next = mid_reg;
                end
            end
            S_PROBE: begin
                // Prime the first move: top entry for insert, next entry for remove
                rd_idx = (op_reg == REQ_INSERT) ? (fill_reg - ONE) : lo_inc;
                case (op_reg)
                    REQ_INSERT: begin
                        if (hit) begin
                            status_next = ST_DUP;
                        end else if (full) begin
                            status_next = ST_FULL;
                        end else begin
                            cur_next = fill_reg;
                        end
                    end
                    REQ_REMOVE: begin
                        if (hit) begin
                            cur_next = lo_reg;
                            if (!(lo_inc < fill_reg)) begin
                                fill_next = fill_reg - ONE;
                            end
                        end else begin
                            status_next = ST_ABSENT;
                        end
                    end
                    REQ_EXISTS: status_next = hit ? ST_OK : ST_ABSENT;
                    REQ_PRED: begin
                        if (lo_reg != '0) begin
                            cur_next = lo_reg - ONE;
                        end else begin
                            status_next = ST_ABSENT;
                        end
                    end
                    REQ_SUCC: begin
                        if (succ_idx < fill_reg) begin
                            cur_next = succ_idx;
                        end else begin
                            status_next = ST_ABSENT;
                        end
                    end
                    default: status_next = ST_OK;
                endcase
            end
            S_FRD: begin
                rd_idx = cur_reg;
            end
            S_FDAT: begin
                value_next = rd_data;
                rd_idx     = cur_inc;
                if (take_reg && !(cur_inc < fill_reg)) begin
                    fill_next = fill_reg - ONE;
                end
            end
            S_UP: begin
                // Move entry cur-1 up into cur, read the one below it
                mem_we   = 1'b1;
                cur_next = cur_dec;
                rd_idx   = cur_reg - TWO;
            end
            S_DN: begin
                // Move entry cur+1 down into cur, read the one above it
                mem_we   = 1'b1;
                cur_next = cur_inc;
                rd_idx   = cur_reg + TWO;
                if (!dn_more) begin
                    fill_next = fill_reg - ONE;
                end
            end
            S_PUT: begin
                mem_we    = 1'b1;
                mem_waddr = lo_reg[AW-1:0];
                mem_wdata = key_reg;
                fill_next = fill_reg + ONE;
            end
            S_DONE: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_status_next = status_reg;
                    m_value_next  = value_ext[KEY_BITS-1:0];
                    m_count_next  = fill_ext[COUNT_BITS-1:0];
                end
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            fill_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload, no reset
    always_ff @(posedge aclk) begin
        op_reg       <= op_next;
        take_reg     <= take_next;
        key_reg      <= key_next;
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        mid_reg      <= mid_next;
        cur_reg      <= cur_next;
        status_reg   <= status_next;
        value_reg    <= value_next;
        m_status_reg <= m_status_next;
        m_value_reg  <= m_value_next;
        m_count_reg  <= m_count_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, m_count_reg, m_value_reg, m_status_reg};

    // Checks
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= FILL_MAX)
        else $error("set count above capacity");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        in_accept |=> state_reg != S_IDLE)
        else $error("sequencer idle right after accepting a request");

    a_write_in_move: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> (state_reg == S_UP || state_reg == S_DN || state_reg == S_PUT))
        else $error("store written outside a move or place step");

    a_full_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DONE && status_reg == ST_FULL) |-> fill_reg == FILL_MAX)
        else $error("full status reported on a set that is not full");

    a_search_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_CMP |-> mid_reg < fill_reg)
        else $error("search read beyond the held entries");

endmodule

[src/sse_mem.sv]
// Key store: single write port, single registered read port.
module sse_mem #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        rdata <= mem[raddr];
    end

endmodule
